// ----- hdl/page_lru_key_value_cache_unit_macros.svh -----
// assertion macros for the cache checker
`ifndef PAGE_LRU_KEY_VALUE_CACHE_UNIT_MACROS_SVH
`define PAGE_LRU_KEY_VALUE_CACHE_UNIT_MACROS_SVH

// checked only outside reset
`define PLKV_ASSERT(lbl, prop) \
   lbl: assert property (@(posedge clock) disable iff (reset) prop) \
      else $error("plkv check failed");

// checked on every edge
`define PLKV_ASSERT_ALWAYS(lbl, prop) \
   lbl: assert property (@(posedge clock) prop) \
      else $error("plkv check failed");

`endif

// ----- hdl/plkv_pkg.sv -----
`default_nettype none
package plkv_pkg;

   localparam int LIMIT_BITS = 4;
   localparam int FILL_BITS  = 3;

   localparam logic CMD_GET = 1'b0;
   localparam logic CMD_SET = 1'b1;

   localparam logic CSR_PAGE_LIMIT = 1'b0;
   localparam logic CSR_PAGE_FILL  = 1'b1;

   localparam logic [LIMIT_BITS-1:0] LIMIT_RESET = 4'd8;
   localparam logic [FILL_BITS-1:0]  FILL_RESET  = 3'd4;

   typedef enum logic [1:0] {
      PG_NONE   = 2'd0,
      PG_TOUCH  = 2'd1,
      PG_UNRANK = 2'd2,
      PG_FRONT  = 2'd3
   } page_op_type;

   typedef struct packed {
      logic wr_en;
      logic wr_key;
      logic erase_en;
   } slot_ctl_type;

   typedef enum logic [6:0] {
      ST_IDLE   = 7'b0000001,
      ST_LOOK   = 7'b0000010,
      ST_ACT    = 7'b0000100,
      ST_VSCAN  = 7'b0001000,
      ST_ERASE  = 7'b0010000,
      ST_INSERT = 7'b0100000,
      ST_DONE   = 7'b1000000
   } state_type;

endpackage
`default_nettype wire

// ----- hdl/plkv_slot_cell.sv -----
`default_nettype none
module plkv_slot_cell #(
   parameter int KEY_BITS   = 32,
   parameter int VALUE_BITS = 32,
   parameter int PW         = 3,
   parameter int SW         = 2,
   parameter int PAGE_ID    = 0,
   parameter int SUB_ID     = 0
) (
   input  wire                     clock,
   input  wire                     reset,
   input  plkv_pkg::slot_ctl_type  ctl,
   input  wire  [PW-1:0]           wr_page,
   input  wire  [SW-1:0]           wr_sub,
   input  wire  [PW-1:0]           clr_page,
   input  wire  [KEY_BITS-1:0]     wr_key_data,
   input  wire  [VALUE_BITS-1:0]   wr_value,
   input  wire  [KEY_BITS-1:0]     look_key,
   output logic                    match,
   output logic [VALUE_BITS-1:0]   value
);
   import plkv_pkg::*;

   logic                  valid_ff;
   logic [KEY_BITS-1:0]   key_ff;
   logic [VALUE_BITS-1:0] value_ff;
   logic                  sel;

   assign sel   = ctl.wr_en && wr_page == PW'(PAGE_ID) && wr_sub == SW'(SUB_ID);
   assign match = valid_ff && key_ff == look_key;
   assign value = value_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (sel && ctl.wr_key) begin
         valid_ff <= 1'b1;
      end else if (ctl.erase_en && clr_page == PW'(PAGE_ID)) begin
         valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (sel) begin
         value_ff <= wr_value;
         if (ctl.wr_key) begin
            key_ff <= wr_key_data;
         end
      end
   end

endmodule
`default_nettype wire

// ----- hdl/plkv_page_cell.sv -----
`default_nettype none
module plkv_page_cell #(
   parameter int PW      = 3,
   parameter int PAGE_ID = 0
) (
   input  wire                    clock,
   input  wire                    reset,
   input  plkv_pkg::page_op_type  op,
   input  wire  [PW-1:0]          op_page,
   input  wire  [PW-1:0]          op_rank,
   output logic                   full,
   output logic [PW-1:0]          rank
);
   import plkv_pkg::*;

   logic          full_ff, full_in;
   logic [PW-1:0] rank_ff, rank_in;
   logic          self;

   assign self = op_page == PW'(PAGE_ID);
   assign full = full_ff;
   assign rank = rank_ff;

   always_comb begin
      full_in = full_ff;
      rank_in = rank_ff;
      case (op)
         PG_TOUCH: begin
            if (self) begin
               rank_in = '0;
            end else if (full_ff && rank_ff < op_rank) begin
               rank_in = rank_ff + 1'b1;
            end
         end
         PG_UNRANK: begin
            if (self) begin
               full_in = 1'b0;
               rank_in = '0;
            end else if (full_ff && rank_ff > op_rank) begin
               rank_in = rank_ff - 1'b1;
            end
         end
         PG_FRONT: begin
            if (self) begin
               full_in = 1'b1;
               rank_in = '0;
            end else if (full_ff) begin
               rank_in = rank_ff + 1'b1;
            end
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         full_ff <= 1'b0;
         rank_ff <= '0;
      end else begin
         full_ff <= full_in;
         rank_ff <= rank_in;
      end
   end

endmodule
`default_nettype wire

// ----- hdl/page_lru_key_value_cache_unit.sv -----
// states: get, set hit and get miss pass IDLE, LOOK, ACT and DONE to the result word
// set miss adds INSERT; when a page is evicted, VSCAN over MAX_PAGES pages and ERASE come first
// a new word is taken only in IDLE, after the last one is through DONE; it is taken while a result waits
// reset: synchronous, clears valid bits, page ranks, open page, counts and config
`default_nettype none
module page_lru_key_value_cache_unit #(
   parameter int MAX_PAGES    = 8,
   parameter int MAX_PER_PAGE = 4,
   parameter int KEY_BITS     = 32,
   parameter int VALUE_BITS   = 32
) (
   input  wire                                        clock,
   input  wire                                        reset,
   input  wire                                        req_tvalid,
   output logic                                       req_tready,
   // lookup_key, new_value
   input  wire  [((KEY_BITS+VALUE_BITS+7)/8)*8-1:0]   req_tdata,
   // command
   input  wire                                        req_tuser,
   output logic                                       rsp_tvalid,
   input  wire                                        rsp_tready,
   // value_out
   output logic [((VALUE_BITS+7)/8)*8-1:0]            rsp_tdata,
   // hit, page_evicted
   output logic [1:0]                                 rsp_tuser,
   input  wire                                        csr_wr_en,
   input  wire                                        csr_index,
   input  wire  [plkv_pkg::LIMIT_BITS-1:0]            csr_wdata
);
   import plkv_pkg::*;

   localparam int PW    = (MAX_PAGES > 1) ? $clog2(MAX_PAGES) : 1;
   localparam int SW    = (MAX_PER_PAGE > 1) ? $clog2(MAX_PER_PAGE) : 1;
   localparam int CW    = $clog2(MAX_PER_PAGE + 1);
   localparam int TW    = $clog2(MAX_PAGES + 1);
   localparam int OUT_W = ((VALUE_BITS + 7) / 8) * 8;

   state_type             state_ff, state_in;
   logic                  cmd_ff;
   logic [KEY_BITS-1:0]   key_ff;
   logic [VALUE_BITS-1:0] val_ff;
   logic                  hit_ff, hit_in;
   logic [VALUE_BITS-1:0] vout_ff, vout_in;
   logic                  evict_ff, evict_in;
   logic [PW-1:0]         fpage_ff, fpage_in;
   logic [SW-1:0]         fsub_ff, fsub_in;
   logic [PW-1:0]         open_idx_ff, open_idx_in;
   logic                  open_ff, open_in;
   logic [CW-1:0]         count_ff, count_in;
   logic [TW-1:0]         taken_ff, taken_in;
   logic [PW-1:0]         scan_ff, scan_in;
   logic [PW-1:0]         victim_ff, victim_in;
   logic [PW-1:0]         best_ff, best_in;
   logic                  any_ff, any_in;
   logic [LIMIT_BITS-1:0] lim_ff;
   logic [FILL_BITS-1:0]  fill_ff;
   logic                  rsp_valid_ff;
   logic [VALUE_BITS-1:0] rsp_value_ff;
   logic                  rsp_hit_ff, rsp_evict_ff;

   logic [MAX_PAGES-1:0][MAX_PER_PAGE-1:0] match_w;
   logic [VALUE_BITS-1:0] sval_w [MAX_PAGES][MAX_PER_PAGE];
   logic [MAX_PAGES-1:0]  full_w;
   logic [PW-1:0]         rank_w [MAX_PAGES];

   page_op_type           pop;
   logic [PW-1:0]         pop_page;
   slot_ctl_type          sctl;
   logic [PW-1:0]         s_page, s_clr_page;
   logic [SW-1:0]         s_sub;
   logic                  look_got;
   logic [PW-1:0]         look_page;
   logic [SW-1:0]         look_sub;
   logic                  can_take, fill_one, page_done;
   logic [CW-1:0]         count_next;

   genvar gp, gs;
   generate
      for (gp = 0; gp < MAX_PAGES; gp++) begin : g_page
         plkv_page_cell #(.PW(PW), .PAGE_ID(gp)) u_page (
            .clock(clock), .reset(reset), .op(pop), .op_page(pop_page),
            .op_rank(rank_w[pop_page]), .full(full_w[gp]), .rank(rank_w[gp])
         );
         for (gs = 0; gs < MAX_PER_PAGE; gs++) begin : g_slot
            plkv_slot_cell #(
               .KEY_BITS(KEY_BITS), .VALUE_BITS(VALUE_BITS), .PW(PW), .SW(SW),
               .PAGE_ID(gp), .SUB_ID(gs)
            ) u_slot (
               .clock(clock), .reset(reset), .ctl(sctl), .wr_page(s_page),
               .wr_sub(s_sub), .clr_page(s_clr_page), .wr_key_data(key_ff),
               .wr_value(val_ff), .look_key(key_ff), .match(match_w[gp][gs]),
               .value(sval_w[gp][gs])
            );
         end
      end
   endgenerate

   always_comb begin
      look_got  = 1'b0;
      look_page = '0;
      look_sub  = '0;
      for (int p = 0; p < MAX_PAGES; p++) begin
         for (int s = 0; s < MAX_PER_PAGE; s++) begin
            if (match_w[p][s] && !look_got) begin
               look_got  = 1'b1;
               look_page = PW'(p);
               look_sub  = SW'(s);
            end
         end
      end
   end

   assign can_take = !open_ff && (8'(taken_ff) < 8'(lim_ff) || 8'(taken_ff) == 8'(0))
                     && 8'(taken_ff) < 8'(MAX_PAGES);
   assign fill_one   = fill_ff <= FILL_BITS'(1) || MAX_PER_PAGE == 1;
   assign count_next = count_ff + 1'b1;
   assign page_done  = 8'(count_next) >= 8'(fill_ff) || 8'(count_next) >= 8'(MAX_PER_PAGE);

   always_comb begin
      state_in     = state_ff;
      hit_in       = hit_ff;
      vout_in      = vout_ff;
      evict_in     = evict_ff;
      fpage_in     = fpage_ff;
      fsub_in      = fsub_ff;
      open_idx_in  = open_idx_ff;
      open_in      = open_ff;
      count_in     = count_ff;
      taken_in     = taken_ff;
      scan_in      = scan_ff;
      victim_in    = victim_ff;
      best_in      = best_ff;
      any_in       = any_ff;
      pop          = PG_NONE;
      pop_page     = '0;
      sctl         = '0;
      s_page       = '0;
      s_sub        = '0;
      s_clr_page   = '0;
      case (state_ff)
         ST_IDLE: begin
            if (req_tvalid) begin
               state_in = ST_LOOK;
            end
         end
         ST_LOOK: begin
            hit_in   = look_got;
            fpage_in = look_page;
            fsub_in  = look_sub;
            evict_in = 1'b0;
            vout_in  = (look_got && cmd_ff == CMD_GET) ? sval_w[look_page][look_sub] : '0;
            state_in = ST_ACT;
         end
         ST_ACT: begin
            state_in = ST_DONE;
            pop_page = fpage_ff;
            if (hit_ff) begin
               if (full_w[fpage_ff]) begin
                  pop = PG_TOUCH;
               end
               if (cmd_ff == CMD_SET) begin
                  sctl.wr_en = 1'b1;
                  s_page     = fpage_ff;
                  s_sub      = fsub_ff;
                  if (fill_one && full_w[fpage_ff] && !open_ff) begin
                     sctl.wr_key   = 1'b1;
                     sctl.erase_en = 1'b1;
                     s_clr_page    = fpage_ff;
                     s_sub         = '0;
                     open_idx_in   = fpage_ff;
                  end
               end
            end else if (cmd_ff == CMD_SET) begin
               if (can_take) begin
                  open_idx_in = PW'(taken_ff);
                  open_in     = 1'b1;
                  count_in    = '0;
                  taken_in    = taken_ff + 1'b1;
                  state_in    = ST_INSERT;
               end else if (!open_ff) begin
                  scan_in   = '0;
                  victim_in = '0;
                  best_in   = '0;
                  any_in    = 1'b0;
                  state_in  = ST_VSCAN;
               end else begin
                  state_in = ST_INSERT;
               end
            end
         end
         ST_VSCAN: begin
            if (full_w[scan_ff] && (!any_ff || rank_w[scan_ff] > best_ff)) begin
               victim_in = scan_ff;
               best_in   = rank_w[scan_ff];
               any_in    = 1'b1;
            end
            scan_in = scan_ff + 1'b1;
            if (scan_ff == PW'(MAX_PAGES - 1)) begin
               state_in = ST_ERASE;
            end
         end
         ST_ERASE: begin
            pop_page      = victim_ff;
            if (full_w[victim_ff]) begin
               pop = PG_UNRANK;
            end
            sctl.erase_en = 1'b1;
            s_clr_page    = victim_ff;
            open_idx_in   = victim_ff;
            open_in       = 1'b1;
            count_in      = '0;
            evict_in      = 1'b1;
            state_in      = ST_INSERT;
         end
         ST_INSERT: begin
            sctl.wr_en  = 1'b1;
            sctl.wr_key = 1'b1;
            s_page      = open_idx_ff;
            s_sub       = SW'(count_ff);
            pop_page    = open_idx_ff;
            if (page_done) begin
               pop      = PG_FRONT;
               open_in  = 1'b0;
               count_in = '0;
            end else begin
               count_in = count_next;
            end
            state_in = ST_DONE;
         end
         ST_DONE: begin
            if (!rsp_valid_ff || rsp_tready) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         open_ff      <= 1'b0;
         open_idx_ff  <= '0;
         count_ff     <= '0;
         taken_ff     <= '0;
         rsp_valid_ff <= 1'b0;
         lim_ff       <= LIMIT_RESET;
         fill_ff      <= FILL_RESET;
      end else begin
         state_ff    <= state_in;
         open_ff     <= open_in;
         open_idx_ff <= open_idx_in;
         count_ff    <= count_in;
         taken_ff    <= taken_in;
         if (state_ff == ST_DONE && (!rsp_valid_ff || rsp_tready)) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_tready) begin
            rsp_valid_ff <= 1'b0;
         end
         if (csr_wr_en) begin
            if (csr_index == CSR_PAGE_LIMIT) begin
               lim_ff <= csr_wdata;
            end else begin
               fill_ff <= csr_wdata[FILL_BITS-1:0];
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      hit_ff    <= hit_in;
      vout_ff   <= vout_in;
      evict_ff  <= evict_in;
      fpage_ff  <= fpage_in;
      fsub_ff   <= fsub_in;
      scan_ff   <= scan_in;
      victim_ff <= victim_in;
      best_ff   <= best_in;
      any_ff    <= any_in;
      if (state_ff == ST_IDLE && req_tvalid) begin
         cmd_ff <= req_tuser;
         key_ff <= req_tdata[KEY_BITS-1:0];
         val_ff <= req_tdata[KEY_BITS+VALUE_BITS-1:KEY_BITS];
      end
      if (state_ff == ST_DONE && (!rsp_valid_ff || rsp_tready)) begin
         rsp_value_ff <= vout_ff;
         rsp_hit_ff   <= hit_ff;
         rsp_evict_ff <= evict_ff;
      end
   end

   assign req_tready = state_ff == ST_IDLE;
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = OUT_W'(rsp_value_ff);
   assign rsp_tuser  = {rsp_evict_ff, rsp_hit_ff};

endmodule
`default_nettype wire

// ----- hdl/plkv_checker.sv -----
`default_nettype none
`include "page_lru_key_value_cache_unit_macros.svh"
module plkv_checker #(
   parameter int OUT_W = 32
) (
   input wire             clock,
   input wire             reset,
   input wire             req_tvalid,
   input wire             req_tready,
   input wire             rsp_tvalid,
   input wire             rsp_tready,
   input wire [OUT_W-1:0] rsp_tdata,
   input wire [1:0]       rsp_tuser
);

   // a stalled result word stays offered
   `PLKV_ASSERT(a_rsp_hold, rsp_tvalid && !rsp_tready |=> rsp_tvalid)

   // an eviction only follows a miss, which returns no value
   `PLKV_ASSERT(a_evict_miss, rsp_tvalid && rsp_tuser[1] |-> !rsp_tuser[0] && rsp_tdata == '0)

   // one word in flight: no new word right after one is taken
   `PLKV_ASSERT(a_one_inflight, req_tvalid && req_tready |=> !req_tready)

   // nothing offered straight out of reset
   `PLKV_ASSERT_ALWAYS(a_reset_quiet, $past(reset) |-> !rsp_tvalid)

endmodule

bind page_lru_key_value_cache_unit plkv_checker #(
   .OUT_W(((VALUE_BITS + 7) / 8) * 8)
) u_plkv_checker (
   .clock(clock), .reset(reset), .req_tvalid(req_tvalid), .req_tready(req_tready),
   .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready), .rsp_tdata(rsp_tdata),
   .rsp_tuser(rsp_tuser)
);
`default_nettype wire
